/* sv/slpc_pkg.sv */
// slpc_pkg: shared constants, types and channel map for the serial LED PWM controller.
// No dependencies; imported by every module of the block.

package slpc_pkg;

	localparam int CHANNELS    = 12;
	localparam int TABLE_DEPTH = 16;
	localparam int NUM_COLOURS = 3;
	localparam int PORT_W      = 6;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_BOOT_CAUSE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD  = 1'b1;

	localparam logic [15:0] HB_PERIOD_RESET = 16'd15625;

	// serial command bytes
	localparam logic [7:0] CMD_NORMAL    = 8'hF0;
	localparam logic [7:0] CMD_CLR_CAUSE = 8'hF8;
	localparam logic [7:0] CMD_CONFIG    = 8'hE0;
	localparam logic [7:0] CMD_VERSION   = 8'hD0;

	localparam logic [7:0] VERSION_BYTE   = 8'h1A;
	localparam logic [7:0] HEARTBEAT_FLAG = 8'h80;

	localparam logic [3:0] HI_NIBBLE_MAX = 4'd12;
	localparam logic [3:0] SLOT_LIMIT    = 4'd12;

	localparam logic [5:0] PWM_LAST = 6'd62;

	localparam logic [5:0] CFG_RED_LAST   = 6'd14;
	localparam logic [5:0] CFG_GREEN_LAST = 6'd29;
	localparam logic [5:0] CFG_BLUE_LAST  = 6'd44;
	localparam logic [5:0] CFG_IDX_MAX    = 6'd63;

	typedef enum logic [1:0] {
		COL_RED   = 2'd0,
		COL_GREEN = 2'd1,
		COL_BLUE  = 2'd2
	} colour_t;

	localparam logic [7:0] GAMMA [TABLE_DEPTH] = '{
		8'd0, 8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd13,
		8'd16, 8'd19, 8'd22, 8'd26, 8'd32, 8'd38, 8'd47, 8'd63
	};

	localparam logic [3:0] CHAN_SLOT [CHANNELS] = '{
		4'd0, 4'd2, 4'd1, 4'd5, 4'd4, 4'd3, 4'd6, 4'd11, 4'd10, 4'd9, 4'd7, 4'd8
	};

	localparam colour_t CHAN_COLOUR [CHANNELS] = '{
		COL_RED, COL_BLUE, COL_GREEN, COL_BLUE, COL_GREEN, COL_RED,
		COL_RED, COL_BLUE, COL_GREEN, COL_RED, COL_GREEN, COL_BLUE
	};

	// update request from the command decoder to the level store
	typedef struct packed {
		logic       phase_we;
		logic       tbl_we;
		colour_t    tbl_sel;
		logic [3:0] tbl_entry;
		logic [7:0] data;
	} slpc_upd_t;

endpackage

/* sv/slpc_if.sv */
// slpc_if: valid/ready channel interfaces for the item input and the result output.
// Depends on nothing.

interface slpc_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;

	modport source (output valid, cmd, rx_byte, input ready);
	modport sink   (input valid, cmd, rx_byte, output ready);
endinterface

interface slpc_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] port_a_bits;
	logic [5:0] port_c_bits;
	logic       tx_valid;
	logic [7:0] tx_byte;

	modport source (output valid, port_a_bits, port_c_bits, tx_valid, tx_byte, input ready);
	modport sink   (input valid, port_a_bits, port_c_bits, tx_valid, tx_byte, output ready);
endinterface

/* sv/serial_led_pwm_controller.sv */
// serial_led_pwm_controller: twelve-channel LED PWM driven by tick and serial byte items.
// Each result is held in the output register, shown in the cycle after its input item.
// Throughput: one item per cycle unless stalled; a new result enters as the old leaves.
// Reset (arst_n low): tables return to the gamma curve, phases, counters, mode and held
// port bits clear, heartbeat period returns to 15625; no clearing pass is needed.
// Depends on slpc_pkg, slpc_if, slpc_ctrl, slpc_levels.

module serial_led_pwm_controller (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [slpc_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [slpc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	slpc_in_if.sink                          in_ch,
	slpc_out_if.source                       out_ch
);
	import slpc_pkg::*;

	logic        accept;
	logic [2:0]  boot_cause_q;
	logic [15:0] hb_period_q;
	slpc_upd_t   upd;
	logic [5:0]  pwm_count;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic [11:0] lit;

	logic        out_valid_q;
	logic [5:0]  port_a_q;
	logic [5:0]  port_c_q;
	logic        tx_valid_q;
	logic [7:0]  tx_byte_q;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_cause_q <= 3'd0;
			hb_period_q  <= HB_PERIOD_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_BOOT_CAUSE: boot_cause_q <= cfg_wdata[2:0];
				REG_HB_PERIOD:  hb_period_q  <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	slpc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.cmd        (in_ch.cmd),
		.rx_byte    (in_ch.rx_byte),
		.boot_cause (boot_cause_q),
		.hb_period  (hb_period_q),
		.upd        (upd),
		.pwm_count  (pwm_count),
		.tx_valid   (tx_valid),
		.tx_byte    (tx_byte)
	);

	slpc_levels u_levels (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.pwm_count (pwm_count),
		.lit       (lit)
	);

	// port registers double as the held port values: byte items leave them unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			port_a_q    <= 6'd0;
			port_c_q    <= 6'd0;
			tx_valid_q  <= 1'b0;
			tx_byte_q   <= 8'd0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
			tx_valid_q  <= tx_valid;
			tx_byte_q   <= tx_byte;
			if (!in_ch.cmd) begin
				port_a_q <= lit[5:0];
				port_c_q <= lit[11:6];
			end
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.port_a_bits = port_a_q;
	assign out_ch.port_c_bits = port_c_q;
	assign out_ch.tx_valid    = tx_valid_q;
	assign out_ch.tx_byte     = tx_byte_q;

endmodule

/* sv/slpc_ctrl.sv */
// slpc_ctrl: command decode, mode and config-index tracking, PWM and heartbeat counters.
// Depends on slpc_pkg.

module slpc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                cmd,
	input  logic [7:0]          rx_byte,
	input  logic [2:0]          boot_cause,
	input  logic [15:0]         hb_period,
	output slpc_pkg::slpc_upd_t upd,
	output logic [5:0]          pwm_count,
	output logic                tx_valid,
	output logic [7:0]          tx_byte
);
	import slpc_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_CONFIG = 2'd2
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [5:0]  cfg_idx_q, cfg_idx_d;
	logic [5:0]  pwm_q, pwm_d;
	logic [15:0] hb_q, hb_d;
	logic        cleared_q, cleared_d;
	logic [16:0] hb_next;
	logic [6:0]  pwm_next;
	logic [3:0]  hi;

	assign hi       = rx_byte[7:4];
	assign hb_next  = {1'b0, hb_q} + 17'd1;
	assign pwm_next = {1'b0, pwm_q} + 7'd1;
	assign pwm_count = pwm_q;

	always_comb begin
		mode_d    = mode_q;
		cfg_idx_d = cfg_idx_q;
		pwm_d     = pwm_q;
		hb_d      = hb_q;
		cleared_d = cleared_q;
		tx_valid  = 1'b0;
		tx_byte   = 8'd0;
		upd       = '0;
		upd.data  = rx_byte;
		if (!cmd) begin
			pwm_d = (pwm_q >= PWM_LAST) ? 6'd0 : pwm_next[5:0];
			if (hb_next >= {1'b0, hb_period}) begin
				hb_d     = 16'd0;
				tx_valid = 1'b1;
				tx_byte  = HEARTBEAT_FLAG | {5'd0, cleared_q ? 3'd0 : boot_cause};
			end else begin
				hb_d = hb_next[15:0];
			end
		end else begin
			case (rx_byte)
				CMD_NORMAL: mode_d = MODE_NORMAL;
				CMD_CLR_CAUSE: cleared_d = 1'b1;
				CMD_CONFIG: begin
					mode_d    = MODE_CONFIG;
					cfg_idx_d = 6'd0;
				end
				CMD_VERSION: begin
					tx_valid = 1'b1;
					tx_byte  = VERSION_BYTE;
				end
				default: begin
					if (hi <= HI_NIBBLE_MAX) begin
						if (mode_q == MODE_CONFIG) begin
							if (cfg_idx_q <= CFG_RED_LAST) begin
								upd.tbl_we    = 1'b1;
								upd.tbl_sel   = COL_RED;
								upd.tbl_entry = cfg_idx_q[3:0] + 4'd1;
							end else if (cfg_idx_q <= CFG_GREEN_LAST) begin
								upd.tbl_we    = 1'b1;
								upd.tbl_sel   = COL_GREEN;
								upd.tbl_entry = 4'(cfg_idx_q - CFG_RED_LAST);
							end else if (cfg_idx_q <= CFG_BLUE_LAST) begin
								upd.tbl_we    = 1'b1;
								upd.tbl_sel   = COL_BLUE;
								upd.tbl_entry = 4'(cfg_idx_q - CFG_GREEN_LAST);
							end else begin
								mode_d = MODE_IDLE;
							end
							if (cfg_idx_q < CFG_IDX_MAX)
								cfg_idx_d = cfg_idx_q + 6'd1;
						end else if (mode_q == MODE_NORMAL && hi < SLOT_LIMIT) begin
							upd.phase_we = 1'b1;
						end
					end
				end
			endcase
		end
		if (!accept) begin
			upd.phase_we = 1'b0;
			upd.tbl_we   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			cfg_idx_q <= 6'd0;
			pwm_q     <= 6'd0;
			hb_q      <= 16'd0;
			cleared_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			cfg_idx_q <= cfg_idx_d;
			pwm_q     <= pwm_d;
			hb_q      <= hb_d;
			cleared_q <= cleared_d;
		end
	end

endmodule

/* sv/slpc_levels.sv */
// slpc_levels: colour tables, channel phases and per-channel brightness with the PWM compare.
// Depends on slpc_pkg.

module slpc_levels (
	input  logic                clk,
	input  logic                arst_n,
	input  slpc_pkg::slpc_upd_t upd,
	input  logic [5:0]          pwm_count,
	output logic [11:0]         lit
);
	import slpc_pkg::*;

	logic [7:0] table_q [NUM_COLOURS][TABLE_DEPTH];
	logic [3:0] phase_q [CHANNELS];
	logic [7:0] level_q [CHANNELS];
	logic [7:0] rd [NUM_COLOURS];

	// one read per table at the new phase value
	always_comb begin
		for (int c = 0; c < NUM_COLOURS; c++)
			rd[c] = table_q[c][upd.data[3:0]];
	end

	always_comb begin
		for (int ch = 0; ch < CHANNELS; ch++)
			lit[ch] = level_q[ch] > {2'b00, pwm_count};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_COLOURS; c++)
				for (int e = 0; e < TABLE_DEPTH; e++)
					table_q[c][e] <= GAMMA[e];
			for (int ch = 0; ch < CHANNELS; ch++) begin
				phase_q[ch] <= 4'd0;
				level_q[ch] <= GAMMA[0];
			end
		end else begin
			if (upd.tbl_we)
				table_q[upd.tbl_sel][upd.tbl_entry] <= upd.data;
			for (int ch = 0; ch < CHANNELS; ch++) begin
				if (upd.phase_we && CHAN_SLOT[ch] == upd.data[7:4]) begin
					phase_q[ch] <= upd.data[3:0];
					level_q[ch] <= rd[CHAN_COLOUR[ch]];
				end
				if (upd.tbl_we && CHAN_COLOUR[ch] == upd.tbl_sel
						&& phase_q[ch] == upd.tbl_entry)
					level_q[ch] <= upd.data;
			end
		end
	end

endmodule

/* sim/testbench.sv */
// testbench: self-checking bench for serial_led_pwm_controller, driving ticks and serial bytes
// through valid/ready channels, checking each result with its behavioral predictor or a typed row.
// Depends on slpc_pkg, slpc_if and the controller RTL.

module testbench;
	import slpc_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NORMAL = 2'd1,
		MODE_CONFIG = 2'd2
	} led_mode_t;

	typedef struct packed {
		logic [5:0] port_a;
		logic [5:0] port_c;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} led_result_t;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  rx_byte;
		logic        typed;
		led_result_t result;
	} led_row_t;

	localparam logic TICK = 1'b0;
	localparam logic RX   = 1'b1;

	localparam logic [7:0] VERSION_REPLY = 8'h1A;
	localparam logic [7:0] HB_MARK       = 8'h80;
	localparam logic [5:0] RED_LAST      = 6'd14;
	localparam logic [5:0] GREEN_LAST    = 6'd29;
	localparam logic [5:0] BLUE_LAST     = 6'd44;
	localparam logic [5:0] PTR_MAX       = 6'd63;
	localparam logic [5:0] PWM_WRAP      = 6'd62;

	localparam int LED_SLOT [12] = '{0, 2, 1, 5, 4, 3, 6, 11, 10, 9, 7, 8};
	localparam colour_t LED_COLOUR [12] = '{
		COL_RED, COL_BLUE, COL_GREEN, COL_BLUE, COL_GREEN, COL_RED,
		COL_RED, COL_BLUE, COL_GREEN, COL_RED, COL_GREEN, COL_BLUE
	};
	localparam logic [7:0] GAMMA_RESET [16] = '{
		8'd0, 8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd13,
		8'd16, 8'd19, 8'd22, 8'd26, 8'd32, 8'd38, 8'd47, 8'd63
	};

	localparam led_result_t QUIET = '0;

	localparam led_row_t DIRECTED [25] = '{
		'{TICK, 8'h00,         1'b1, QUIET},
		'{RX,   8'h35,         1'b1, QUIET},
		'{RX,   CMD_VERSION,   1'b1, '{6'h00, 6'h00, 1'b1, VERSION_REPLY}},
		'{RX,   CMD_NORMAL,    1'b1, QUIET},
		'{RX,   8'h0F,         1'b1, QUIET},
		'{RX,   8'hBF,         1'b1, QUIET},
		'{RX,   8'hC7,         1'b1, QUIET},
		'{RX,   8'hDF,         1'b1, QUIET},
		'{TICK, 8'hFF,         1'b0, QUIET},
		'{RX,   8'h5A,         1'b0, QUIET},
		'{RX,   8'h27,         1'b0, QUIET},
		'{TICK, 8'h00,         1'b0, QUIET},
		'{RX,   8'hFF,         1'b0, QUIET},
		'{RX,   CMD_CONFIG,    1'b0, QUIET},
		'{RX,   8'h00,         1'b0, QUIET},
		'{RX,   8'hC8,         1'b0, QUIET},
		'{RX,   8'h7F,         1'b0, QUIET},
		'{RX,   8'h3C,         1'b0, QUIET},
		'{RX,   CMD_NORMAL,    1'b0, QUIET},
		'{RX,   8'h02,         1'b0, QUIET},
		'{RX,   8'h91,         1'b0, QUIET},
		'{TICK, 8'h00,         1'b0, QUIET},
		'{TICK, 8'h5A,         1'b0, QUIET},
		'{RX,   8'hE5,         1'b0, QUIET},
		'{RX,   CMD_VERSION,   1'b0, QUIET}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	slpc_in_if  in_ch ();
	slpc_out_if out_ch ();

	serial_led_pwm_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// predictor state
	logic [3:0]  phase_q [12];
	logic [7:0]  level_tbl [3][16];
	logic [5:0]  pwm_cnt;
	led_mode_t   mode_q;
	logic [5:0]  cfg_ptr;
	logic [15:0] hb_cnt;
	logic        cause_clr;
	logic [5:0]  hold_a;
	logic [5:0]  hold_c;
	logic [2:0]  cause_reg;
	logic [15:0] period_reg;

	led_result_t expected_results [$];

	logic        stim_typed;
	led_result_t stim_result;

	int send_gap_pct;
	int recv_stall_pct;
	int errors;
	int checked;
	int heartbeats;
	int versions;
	int overruns;
	int cfg_writes;

	function automatic logic [7:0] led_level(input int ch);
		return level_tbl[LED_COLOUR[ch]][phase_q[LED_SLOT[ch]]];
	endfunction

	function automatic led_result_t predict_leds(input logic kind, input logic [7:0] b);
		led_result_t r;
		logic [16:0] nxt;
		logic [5:0]  idx;
		r = '0;
		if (kind == TICK) begin
			for (int ch = 0; ch < 6; ch++) begin
				hold_a[ch] = led_level(ch) > pwm_cnt;
				hold_c[ch] = led_level(ch + 6) > pwm_cnt;
			end
			pwm_cnt = (pwm_cnt >= PWM_WRAP) ? 6'd0 : pwm_cnt + 6'd1;
			nxt = {1'b0, hb_cnt} + 17'd1;
			if (nxt >= {1'b0, period_reg}) begin
				hb_cnt = '0;
				r.tx_valid = 1'b1;
				r.tx_byte = HB_MARK | {5'd0, cause_clr ? 3'd0 : cause_reg};
			end else begin
				hb_cnt = nxt[15:0];
			end
		end else if (b == CMD_NORMAL) begin
			mode_q = MODE_NORMAL;
		end else if (b == CMD_CLR_CAUSE) begin
			cause_clr = 1'b1;
		end else if (b == CMD_CONFIG) begin
			mode_q = MODE_CONFIG;
			cfg_ptr = '0;
		end else if (b == CMD_VERSION) begin
			r.tx_valid = 1'b1;
			r.tx_byte = VERSION_REPLY;
		end else if (b[7:4] <= 4'd12) begin
			if (mode_q == MODE_CONFIG) begin
				idx = cfg_ptr;
				if (idx <= RED_LAST)
					level_tbl[COL_RED][idx[3:0] + 4'd1] = b;
				else if (idx <= GREEN_LAST)
					level_tbl[COL_GREEN][4'(idx - RED_LAST)] = b;
				else if (idx <= BLUE_LAST)
					level_tbl[COL_BLUE][4'(idx - GREEN_LAST)] = b;
				else begin
					mode_q = MODE_IDLE;
					overruns++;
				end
				if (cfg_ptr < PTR_MAX)
					cfg_ptr++;
			end else if (mode_q == MODE_NORMAL && b[7:4] < 4'd12) begin
				phase_q[b[7:4]] = b[3:0];
			end
		end
		r.port_a = hold_a;
		r.port_c = hold_c;
		return r;
	endfunction

	function void check_field(input string fname, input int unsigned want, input int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, fname, want, got);
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin : scoreboard
		led_result_t want;
		led_result_t got;
		if (cfg_we) begin
			if (cfg_idx == REG_BOOT_CAUSE)
				cause_reg = cfg_wdata[2:0];
			else if (cfg_idx == REG_HB_PERIOD)
				period_reg = cfg_wdata[15:0];
		end
		if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got = {out_ch.port_a_bits, out_ch.port_c_bits, out_ch.tx_valid, out_ch.tx_byte};
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
			end else begin
				want = expected_results.pop_front();
				check_field("port_a_bits", want.port_a, got.port_a);
				check_field("port_c_bits", want.port_c, got.port_c);
				check_field("tx_valid", want.tx_valid, got.tx_valid);
				check_field("tx_byte", want.tx_byte, got.tx_byte);
				checked++;
				if (want.tx_valid && want.tx_byte[7])
					heartbeats++;
				else if (want.tx_valid)
					versions++;
			end
		end
		if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
			want = predict_leds(in_ch.cmd, in_ch.rx_byte);
			expected_results.push_back(stim_typed ? stim_result : want);
		end
	end

	task automatic send_item(input logic kind, input logic [7:0] data, input logic typed,
			input led_result_t typed_res);
		if ($urandom_range(0, 99) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= kind;
		in_ch.rx_byte <= data;
		stim_typed <= typed;
		stim_result <= typed_res;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	task automatic send_rx(input logic [7:0] data);
		send_item(RX, data, 1'b0, QUIET);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	// mostly well-formed command sequences, some noise bytes on top
	task automatic run_phase(input int n_items, input bit clear_ok);
		int sent;
		int len;
		int pick;
		logic [7:0] b;
		sent = 0;
		while (sent < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				len = $urandom_range(1, 24);
				repeat (len) send_item(TICK, 8'($urandom), 1'b0, QUIET);
				sent += len;
			end else if (pick < 58) begin
				send_rx(CMD_NORMAL);
				len = $urandom_range(1, 8);
				repeat (len) send_rx({4'($urandom_range(0, 12)), 4'($urandom)});
				sent += len + 1;
			end else if (pick < 75) begin
				send_rx(CMD_CONFIG);
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(44, 48) : $urandom_range(1, 16);
				repeat (len) send_rx(8'($urandom_range(0, 8'hCF)));
				sent += len + 1;
				if ($urandom_range(0, 1)) begin
					send_rx(CMD_NORMAL);
					sent++;
				end
			end else if (pick < 82) begin
				send_rx(CMD_VERSION);
				sent++;
			end else begin
				b = 8'($urandom);
				if (b == CMD_CLR_CAUSE && !clear_ok)
					b = CMD_VERSION;
				send_rx(b);
				sent++;
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.cmd <= 1'b0;
		in_ch.rx_byte <= '0;
		stim_typed <= 1'b0;
		stim_result <= QUIET;
		errors = 0;
		checked = 0;
		heartbeats = 0;
		versions = 0;
		overruns = 0;
		cfg_writes = 0;
		send_gap_pct = 13;
		recv_stall_pct = 45;

		foreach (phase_q[i])
			phase_q[i] = '0;
		for (int c = 0; c < 3; c++)
			for (int e = 0; e < 16; e++)
				level_tbl[c][e] = GAMMA_RESET[e];
		pwm_cnt = '0;
		mode_q = MODE_IDLE;
		cfg_ptr = '0;
		hb_cnt = '0;
		cause_clr = 1'b0;
		hold_a = '0;
		hold_c = '0;
		cause_reg = '0;
		period_reg = 16'd15625;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int row = 0; row < $size(DIRECTED); row++)
			send_item(DIRECTED[row].cmd, DIRECTED[row].rx_byte, DIRECTED[row].typed,
				DIRECTED[row].result);
		wait_drained();

		cfg_write(REG_BOOT_CAUSE, 16'd1);
		cfg_write(REG_HB_PERIOD, 16'd1);
		run_phase(250, 1'b0);
		wait_drained();

		// out-of-range cause, heartbeat on every tick
		cfg_write(REG_BOOT_CAUSE, 16'hFFFF);
		cfg_write(REG_HB_PERIOD, 16'd0);
		run_phase(250, 1'b0);
		wait_drained();

		send_gap_pct = 45;
		recv_stall_pct = 13;
		cfg_write(REG_BOOT_CAUSE, 16'd3);
		cfg_write(REG_HB_PERIOD, 16'hFFFF);
		run_phase(250, 1'b0);
		wait_drained();

		// period drops below the running count
		cfg_write(REG_BOOT_CAUSE, 16'd4);
		cfg_write(REG_HB_PERIOD, 16'd13);
		repeat (4) begin
			run_phase(60, 1'b0);
			wait_drained();
		end

		send_gap_pct = 0;
		recv_stall_pct = 0;
		cfg_write(REG_BOOT_CAUSE, 16'd2);
		cfg_write(REG_HB_PERIOD, 16'd40);
		run_phase(250, 1'b0);
		wait_drained();

		cfg_write(REG_BOOT_CAUSE, 16'd5);
		cfg_write(REG_HB_PERIOD, 16'd3);
		run_phase(130, 1'b0);
		send_rx(CMD_CLR_CAUSE);
		run_phase(130, 1'b1);
		wait_drained();

		// cleared cause must survive a new boot_cause
		cfg_write(REG_BOOT_CAUSE, 16'd6);
		cfg_write(REG_HB_PERIOD, 16'd2);
		run_phase(150, 1'b1);
		wait_drained();

		$display("checked %0d transactions: %0d heartbeat bytes, %0d version replies",
			checked, heartbeats, versions);
		$display("%0d config overruns, %0d register writes", overruns, cfg_writes);
		if (errors == 0 && expected_results.size() == 0)
			$display("serial_led_pwm_controller: match");
		else
			$display("serial_led_pwm_controller: mismatch");
		$finish;
	end

	initial begin
		#(12 * 200000);
		$display("timeout with %0d results outstanding", expected_results.size());
		$display("serial_led_pwm_controller: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
sv/slpc_pkg.sv
sv/slpc_if.sv
sv/slpc_ctrl.sv
sv/slpc_levels.sv
sv/serial_led_pwm_controller.sv
sim/testbench.sv
